/* sv/lsrdc_pkg.sv */
// ============================================================================
// lsrdc_pkg
// Shared widths, constants and types of the light-seeking robot drive
// controller.
// ============================================================================
`default_nettype none

package lsrdc_pkg;

    // Field widths of the transfer channels and the configuration port.
    localparam int LIGHT_W    = 12;
    localparam int DUTY_W     = 8;
    localparam int PRESS_W    = 9;
    localparam int REV_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int THR_W      = 12;
    localparam int MODE_W     = 3;

    // Default resolution of the light samples.
    localparam int SAMPLE_BITS_DEF = 12;

    // Button timing in ticks.
    localparam logic [PRESS_W-1:0] SHORT_PRESS = PRESS_W'(500);
    localparam logic [PRESS_W-1:0] PRESS_MAX   = PRESS_W'(511);

    // Duties used during the obstacle reverse phase.
    localparam logic [DUTY_W-1:0] REVERSE_DUTY = DUTY_W'(200);
    localparam logic [DUTY_W-1:0] REVERSE_LED  = DUTY_W'(255);
    localparam logic [DUTY_W-1:0] DUTY_MAX     = DUTY_W'(255);

    // Lower ends of the light maps.
    localparam logic [DUTY_W-1:0] LED_MAP_LO   = DUTY_W'(10);
    localparam logic [DUTY_W-1:0] MOTOR_MAP_LO = DUTY_W'(70);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_LEFT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_RIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_LEDS  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_MS   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_FLAGS   = CFG_IDX_W'(5);

    // Bit positions in the mode flags register.
    localparam int MODE_LIGHT    = 0;
    localparam int MODE_OBST     = 1;
    localparam int MODE_PARALLEL = 2;

    // One result item.
    typedef struct packed {
        logic [DUTY_W-1:0] motor_left_fwd;
        logic [DUTY_W-1:0] motor_left_back;
        logic [DUTY_W-1:0] motor_right_fwd;
        logic [DUTY_W-1:0] motor_right_back;
        logic [DUTY_W-1:0] led_left;
        logic [DUTY_W-1:0] led_right;
        logic              running;
        logic              app_mode;
        logic              reversing;
    } t_result;

endpackage

`default_nettype wire

/* sv/lsrdc_in_if.sv */
// ============================================================================
// lsrdc_in_if
// Input channel: one tick of button, obstacle, light and app command data.
// ============================================================================
`default_nettype none

interface lsrdc_in_if;
    import lsrdc_pkg::*;

    logic               valid;
    logic               ready;
    logic               button_level;
    logic               obstacle_level;
    logic [LIGHT_W-1:0] light_left;
    logic [LIGHT_W-1:0] light_right;
    logic               app_cmd_valid;
    logic               app_cmd_state;

    modport source (
        output valid, button_level, obstacle_level, light_left, light_right,
               app_cmd_valid, app_cmd_state,
        input  ready
    );

    modport sink (
        input  valid, button_level, obstacle_level, light_left, light_right,
               app_cmd_valid, app_cmd_state,
        output ready
    );

endinterface

`default_nettype wire

/* sv/lsrdc_out_if.sv */
// ============================================================================
// lsrdc_out_if
// Output channel: motor and LED duties and the status flags of one tick.
// ============================================================================
`default_nettype none

interface lsrdc_out_if;
    import lsrdc_pkg::*;

    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] motor_left_fwd;
    logic [DUTY_W-1:0] motor_left_back;
    logic [DUTY_W-1:0] motor_right_fwd;
    logic [DUTY_W-1:0] motor_right_back;
    logic [DUTY_W-1:0] led_left;
    logic [DUTY_W-1:0] led_right;
    logic              running;
    logic              app_mode;
    logic              reversing;

    modport source (
        output valid, motor_left_fwd, motor_left_back, motor_right_fwd,
               motor_right_back, led_left, led_right, running, app_mode, reversing,
        input  ready
    );

    modport sink (
        input  valid, motor_left_fwd, motor_left_back, motor_right_fwd,
               motor_right_back, led_left, led_right, running, app_mode, reversing,
        output ready
    );

endinterface

`default_nettype wire

/* sv/light_seeking_robot_drive_controller.sv */
// ============================================================================
// light_seeking_robot_drive_controller
// Drive and LED controller of a two-motor light-seeking robot, one input
// transfer per millisecond tick and one result transfer per tick.
// ============================================================================
// The result of each tick leaves through an output register. In light mode
// while running, not in app mode and not reversing, the LED maps and, when
// either sample lies above the threshold, the two forward motor maps are
// worked out one after another on a single shared map unit whose divider
// retires one quotient bit per cycle. No new tick is taken until the current
// one has been handed to the output register.
`default_nettype none

module light_seeking_robot_drive_controller #(
    parameter int SAMPLE_BITS = lsrdc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [lsrdc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [lsrdc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    lsrdc_in_if.sink                               i_in,
    lsrdc_out_if.source                            o_out
);
    import lsrdc_pkg::*;

    localparam int XW = (SAMPLE_BITS > LIGHT_W) ? SAMPLE_BITS : LIGHT_W;
    localparam logic [XW-1:0] FULL = XW'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [4*DUTY_W-1:0] REV_MOTORS =
        {DUTY_W'(0), REVERSE_DUTY, DUTY_W'(0), REVERSE_DUTY};

    typedef enum logic [2:0] {S_IDLE, S_LED_L, S_LED_R, S_MOT_L, S_MOT_R, S_OUT} t_state;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_man_left;
    logic [CFG_DATA_W-1:0] r_man_right;
    logic [CFG_DATA_W-1:0] r_man_leds;
    logic [THR_W-1:0]      r_thr;
    logic [REV_W-1:0]      r_rev_ms;
    logic [MODE_W-1:0]     r_mode;

    // Control state.
    t_state                r_state;
    logic                  r_run;
    logic                  r_app;
    logic                  r_btn_prev;
    logic [PRESS_W-1:0]    r_press;
    logic [REV_W-1:0]      r_rev_cnt;
    logic [4*DUTY_W-1:0]   r_held;
    logic                  r_started;
    logic                  r_drive;
    logic                  r_out_valid;

    // Working result, light samples and output register.
    t_result               r_work;
    t_result               r_out;
    logic [XW-1:0]         r_ll;
    logic [XW-1:0]         r_lr;

    // Next values worked out in the cycle a tick is taken.
    logic                  n_run;
    logic                  n_app;
    logic                  n_btn_prev;
    logic [PRESS_W-1:0]    n_press;
    logic [REV_W-1:0]      n_rev_cnt;
    logic                  n_rev;
    logic                  n_maps;
    logic                  n_drive;
    logic [4*DUTY_W-1:0]   n_motors;
    t_result               n_res;

    logic                  in_xfer;
    logic [XW-1:0]         ll_m;
    logic [XW-1:0]         lr_m;
    logic [XW-1:0]         thr_x;
    logic                  obst;
    logic [4*DUTY_W-1:0]   held_eff;

    logic                  map_start;
    logic [XW-1:0]         map_x;
    logic [DUTY_W-1:0]     map_lo;
    logic                  map_done;
    logic [DUTY_W-1:0]     map_result;

    assign in_xfer    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // Light samples keep their low SAMPLE_BITS bits.
    assign ll_m  = XW'(i_in.light_left) & FULL;
    assign lr_m  = XW'(i_in.light_right) & FULL;
    assign thr_x = XW'(r_thr);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_man_left  <= '0;
            r_man_right <= '0;
            r_man_leds  <= '0;
            r_thr       <= '0;
            r_rev_ms    <= '0;
            r_mode      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MANUAL_LEFT:  r_man_left  <= i_cfg_data;
                CFG_MANUAL_RIGHT: r_man_right <= i_cfg_data;
                CFG_MANUAL_LEDS:  r_man_leds  <= i_cfg_data;
                CFG_THRESHOLD:    r_thr       <= i_cfg_data[THR_W-1:0];
                CFG_REVERSE_MS:   r_rev_ms    <= i_cfg_data[REV_W-1:0];
                CFG_MODE_FLAGS:   r_mode      <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Flags, button, reverse phase and the drive choice of one tick.
    always_comb begin
        n_run      = r_run;
        n_app      = r_app;
        n_btn_prev = r_btn_prev;
        n_press    = r_press;
        n_rev_cnt  = r_rev_cnt;
        n_rev      = 1'b0;
        n_maps     = 1'b0;
        n_drive    = 1'b0;
        obst       = 1'b0;
        held_eff   = r_held;
        n_motors   = r_held;
        n_res      = '0;
        n_res.led_left  = r_man_leds[2*DUTY_W-1:DUTY_W];
        n_res.led_right = r_man_leds[DUTY_W-1:0];

        // An app command is applied first, even during a reverse phase.
        if (i_in.app_cmd_valid) begin
            n_run = 1'b1;
            n_app = i_in.app_cmd_state;
        end

        if (r_rev_cnt != '0) begin
            n_rev_cnt = r_rev_cnt - 1'b1;
            n_rev     = 1'b1;
        end else begin
            // Press length is counted from the rising edge of the button.
            if (i_in.button_level != r_btn_prev) begin
                if (i_in.button_level) begin
                    n_press = PRESS_W'(1);
                end else if (r_press < SHORT_PRESS) begin
                    n_app = ~n_app;
                    n_run = 1'b1;
                end else begin
                    n_app = 1'b0;
                    n_run = 1'b0;
                end
            end else if (i_in.button_level && (r_press < PRESS_MAX)) begin
                n_press = r_press + 1'b1;
            end
            n_btn_prev = i_in.button_level;

            // An obstacle loads the reverse duties; with no reverse time app or light mode may replace them.
            obst = n_run && r_mode[MODE_OBST] && !i_in.obstacle_level;
            if (obst) begin
                held_eff = REV_MOTORS;
                if (r_rev_ms != '0) begin
                    n_rev_cnt = r_rev_ms - 1'b1;
                    n_rev     = 1'b1;
                end
            end

            // A reverse phase that starts in this tick takes over the drive.
            if (!n_rev) begin
                n_motors = held_eff;
                if (n_run && n_app) begin
                    n_motors = {r_man_left, r_man_right};
                end else if (n_run && r_mode[MODE_LIGHT]) begin
                    n_maps   = 1'b1;
                    n_drive  = (lr_m > thr_x) || (ll_m > thr_x);
                    n_motors = '0;
                end else if (!n_run) begin
                    n_motors = '0;
                end
            end
        end

        if (n_rev) begin
            n_motors        = REV_MOTORS;
            n_res.led_left  = REVERSE_LED;
            n_res.led_right = REVERSE_LED;
        end

        n_res.motor_left_fwd   = n_motors[4*DUTY_W-1:3*DUTY_W];
        n_res.motor_left_back  = n_motors[3*DUTY_W-1:2*DUTY_W];
        n_res.motor_right_fwd  = n_motors[2*DUTY_W-1:DUTY_W];
        n_res.motor_right_back = n_motors[DUTY_W-1:0];
        n_res.running          = n_run;
        n_res.app_mode         = n_app;
        n_res.reversing        = n_rev;
    end

    // Operand selection for the shared map unit; cross wiring swaps the sides.
    always_comb begin
        map_x  = r_ll;
        map_lo = LED_MAP_LO;
        case (r_state)
            S_LED_R: map_x = r_lr;
            S_MOT_L: begin
                map_x  = r_mode[MODE_PARALLEL] ? r_ll : r_lr;
                map_lo = MOTOR_MAP_LO;
            end
            S_MOT_R: begin
                map_x  = r_mode[MODE_PARALLEL] ? r_lr : r_ll;
                map_lo = MOTOR_MAP_LO;
            end
            default: ;
        endcase
    end

    assign map_start = !r_started && ((r_state == S_LED_L) || (r_state == S_LED_R) ||
                                      (r_state == S_MOT_L) || (r_state == S_MOT_R));

    lsrdc_map #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (map_start),
        .i_x      (map_x),
        .i_thr    (thr_x),
        .i_lo     (map_lo),
        .o_done   (map_done),
        .o_result (map_result)
    );

    // Sequencer: take a tick, run the needed maps, hand over the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run       <= 1'b0;
            r_app       <= 1'b0;
            r_btn_prev  <= 1'b0;
            r_press     <= '0;
            r_rev_cnt   <= '0;
            r_held      <= '0;
            r_started   <= 1'b0;
            r_drive     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // The output register empties on a transfer unless it is refilled.
            if (o_out.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_run      <= n_run;
                        r_app      <= n_app;
                        r_btn_prev <= n_btn_prev;
                        r_press    <= n_press;
                        r_rev_cnt  <= n_rev_cnt;
                        r_work     <= n_res;
                        r_ll       <= ll_m;
                        r_lr       <= lr_m;
                        r_drive    <= n_drive;
                        r_state    <= n_maps ? S_LED_L : S_OUT;
                    end
                end
                S_LED_L: begin
                    if (!r_started) begin
                        r_started <= 1'b1;
                    end else if (map_done) begin
                        r_started       <= 1'b0;
                        r_work.led_left <= map_result;
                        r_state         <= S_LED_R;
                    end
                end
                S_LED_R: begin
                    if (!r_started) begin
                        r_started <= 1'b1;
                    end else if (map_done) begin
                        r_started        <= 1'b0;
                        r_work.led_right <= map_result;
                        r_state          <= r_drive ? S_MOT_L : S_OUT;
                    end
                end
                S_MOT_L: begin
                    if (!r_started) begin
                        r_started <= 1'b1;
                    end else if (map_done) begin
                        r_started             <= 1'b0;
                        r_work.motor_left_fwd <= map_result;
                        r_state               <= S_MOT_R;
                    end
                end
                S_MOT_R: begin
                    if (!r_started) begin
                        r_started <= 1'b1;
                    end else if (map_done) begin
                        r_started              <= 1'b0;
                        r_work.motor_right_fwd <= map_result;
                        r_state                <= S_OUT;
                    end
                end
                S_OUT: begin
                    // The motor duties of a finished tick become the held value.
                    if (!r_out_valid || o_out.ready) begin
                        r_out       <= r_work;
                        r_out_valid <= 1'b1;
                        r_held      <= {r_work.motor_left_fwd, r_work.motor_left_back,
                                        r_work.motor_right_fwd, r_work.motor_right_back};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output channel.
    assign o_out.valid            = r_out_valid;
    assign o_out.motor_left_fwd   = r_out.motor_left_fwd;
    assign o_out.motor_left_back  = r_out.motor_left_back;
    assign o_out.motor_right_fwd  = r_out.motor_right_fwd;
    assign o_out.motor_right_back = r_out.motor_right_back;
    assign o_out.led_left         = r_out.led_left;
    assign o_out.led_right        = r_out.led_right;
    assign o_out.running          = r_out.running;
    assign o_out.app_mode         = r_out.app_mode;
    assign o_out.reversing        = r_out.reversing;

    // A reverse tick drives both motors backward and both LEDs fully on.
    a_reverse_duties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.reversing |->
            o_out.motor_left_fwd == '0 && o_out.motor_right_fwd == '0 &&
            o_out.motor_left_back == REVERSE_DUTY &&
            o_out.motor_right_back == REVERSE_DUTY &&
            o_out.led_left == REVERSE_LED && o_out.led_right == REVERSE_LED)
        else $error("reverse tick with wrong duties");

    // The motors are stopped whenever the block is not running.
    a_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.running && !o_out.reversing |->
            o_out.motor_left_fwd == '0 && o_out.motor_left_back == '0 &&
            o_out.motor_right_fwd == '0 && o_out.motor_right_back == '0)
        else $error("motors driven while not running");

    // Every tick taken during a reverse phase shortens it by one.
    a_reverse_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && r_rev_cnt != '0 |=> r_rev_cnt == $past(r_rev_cnt) - 1'b1)
        else $error("reverse counter did not step");

    // A finished tick waits while the output register is still occupied.
    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && r_out_valid && !o_out.ready |=> r_state == S_OUT)
        else $error("result overwrote a pending transfer");

endmodule

`default_nettype wire

/* sv/lsrdc_map.sv */
// ============================================================================
// lsrdc_map
// Saturating linear light map, lo + trunc((x - thr) * (255 - lo) / (FULL - thr)),
// built round a bit-serial restoring divider that retires one quotient bit
// per cycle.
// ============================================================================
`default_nettype none

module lsrdc_map #(
    parameter int  SAMPLE_BITS = lsrdc_pkg::SAMPLE_BITS_DEF,
    localparam int XW = (SAMPLE_BITS > lsrdc_pkg::LIGHT_W) ? SAMPLE_BITS
                                                            : lsrdc_pkg::LIGHT_W
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [XW-1:0]                 i_x,
    input  wire logic [XW-1:0]                 i_thr,
    input  wire logic [lsrdc_pkg::DUTY_W-1:0]  i_lo,
    output logic                               o_done,
    output logic [lsrdc_pkg::DUTY_W-1:0]       o_result
);
    import lsrdc_pkg::*;

    localparam int PW = XW + DUTY_W;
    localparam int CW = $clog2(PW);
    localparam logic [XW-1:0] FULL = XW'((64'd1 << SAMPLE_BITS) - 64'd1);

    typedef enum logic [2:0] {M_IDLE, M_PREP, M_MUL, M_DIV, M_FIN} t_mstate;

    t_mstate             r_state;
    logic [XW-1:0]       r_x;
    logic [XW-1:0]       r_thr;
    logic [DUTY_W-1:0]   r_lo;
    logic [XW-1:0]       r_num_mag;
    logic [XW-1:0]       r_den_mag;
    logic                r_neg;
    logic                r_den_zero;
    logic                r_num_zero;
    logic [XW:0]         r_rem;
    logic [PW-1:0]       r_sh;
    logic [CW-1:0]       r_cnt;
    logic                r_done;
    logic [DUTY_W-1:0]   r_result;

    logic signed [XW:0]  num;
    logic signed [XW:0]  den;
    logic [XW:0]         num_abs;
    logic [XW:0]         den_abs;
    logic [DUTY_W-1:0]   span;
    logic [PW-1:0]       prod;
    logic [XW:0]         rem_sh;
    logic                ge;
    logic [XW:0]         rem_nx;
    logic [DUTY_W-1:0]   sat;

    // Signed numerator and denominator and their magnitudes.
    assign num     = $signed({1'b0, r_x}) - $signed({1'b0, r_thr});
    assign den     = $signed({1'b0, FULL}) - $signed({1'b0, r_thr});
    assign num_abs = num[XW] ? (XW+1)'(0) - num : num;
    assign den_abs = den[XW] ? (XW+1)'(0) - den : den;

    // Scaled numerator, taken by the divider as its dividend.
    assign span = DUTY_MAX - r_lo;
    assign prod = PW'(r_num_mag) * PW'(span);

    // One restoring division step.
    assign rem_sh = {r_rem[XW-1:0], r_sh[PW-1]};
    assign ge     = rem_sh >= {1'b0, r_den_mag};
    assign rem_nx = ge ? rem_sh - {1'b0, r_den_mag} : rem_sh;

    // Apply the sign, add the lower end and saturate to the duty range.
    always_comb begin
        if (r_den_zero) begin
            sat = r_num_zero ? r_lo : '0;
        end else if (!r_neg) begin
            sat = (r_sh > PW'(span)) ? DUTY_MAX : r_lo + r_sh[DUTY_W-1:0];
        end else begin
            sat = (r_sh >= PW'(r_lo)) ? '0 : r_lo - r_sh[DUTY_W-1:0];
        end
    end

    // Sequencer of the map unit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_x;
                        r_thr   <= i_thr;
                        r_lo    <= i_lo;
                        r_state <= M_PREP;
                    end
                end
                M_PREP: begin
                    r_num_mag  <= num_abs[XW-1:0];
                    r_den_mag  <= den_abs[XW-1:0];
                    r_neg      <= num[XW] ^ den[XW];
                    r_num_zero <= (num == '0);
                    r_den_zero <= (den == '0);
                    r_state    <= (den == '0) ? M_FIN : M_MUL;
                end
                M_MUL: begin
                    r_sh    <= prod;
                    r_rem   <= '0;
                    r_cnt   <= CW'(PW - 1);
                    r_state <= M_DIV;
                end
                M_DIV: begin
                    r_rem <= rem_nx;
                    r_sh  <= {r_sh[PW-2:0], ge};
                    if (r_cnt == '0) begin
                        r_state <= M_FIN;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                M_FIN: begin
                    r_result <= sat;
                    r_done   <= 1'b1;
                    r_state  <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ============================================================================
// tb_top
// Self-checking testbench of the light-seeking robot drive controller.
// ============================================================================
// Ticks go in through the input channel and a predictor, kept alongside the
// block with its own copy of the flags, the button counter, the reverse timer
// and the held motor duties, works out the result of every accepted tick.
// A checker compares each result transfer, field by field, with the oldest
// prediction. Directed tests cover the stopped state, app control, short and
// long button presses, the light maps and the obstacle reverse phase. A long
// receiver stall is also tested. Random traffic with changing register settings
// then runs under three idling patterns.
// ============================================================================

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lsrdc_pkg::*;

    localparam int SAMPLE_BITS  = SAMPLE_BITS_DEF;
    localparam int FULL_SCALE   = (1 << SAMPLE_BITS) - 1;
    localparam int CLK_HALF     = 4;
    localparam int TICK_LATENCY = 120;
    localparam int MAX_REPORTS  = 200;
    localparam int RANDOM_BLOCK = 48;

    localparam logic [CFG_DATA_W-1:0] MODE_NONE        = '0;
    localparam logic [CFG_DATA_W-1:0] MODE_LIGHT_ON    = CFG_DATA_W'(1 << MODE_LIGHT);
    localparam logic [CFG_DATA_W-1:0] MODE_OBST_ON     = CFG_DATA_W'(1 << MODE_OBST);
    localparam logic [CFG_DATA_W-1:0] MODE_PARALLEL_ON = CFG_DATA_W'(1 << MODE_PARALLEL);

    // One tick as offered on the input channel.
    typedef struct packed {
        logic               button_level;
        logic               obstacle_level;
        logic [LIGHT_W-1:0] light_left;
        logic [LIGHT_W-1:0] light_right;
        logic               app_cmd_valid;
        logic               app_cmd_state;
    } t_tick;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    lsrdc_in_if  tick_ch();
    lsrdc_out_if drive_ch();

    light_seeking_robot_drive_controller #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (tick_ch),
        .o_out      (drive_ch)
    );

    // Register copies held by the predictor.
    logic [CFG_DATA_W-1:0] man_left_drv;
    logic [CFG_DATA_W-1:0] man_right_drv;
    logic [CFG_DATA_W-1:0] man_leds;
    logic [THR_W-1:0]      light_thr;
    logic [REV_W-1:0]      rev_len;
    logic [MODE_W-1:0]     mode_bits;

    // Controller state held by the predictor.
    logic                  run_on;
    logic                  app_on;
    logic                  btn_was;
    logic [PRESS_W-1:0]    press_ticks;
    logic [REV_W-1:0]      rev_ticks_left;
    logic [4*DUTY_W-1:0]   held_duty;

    // Predicted results waiting for their transfer.
    t_result pending_drive[$];

    int n_errors;
    int n_reports;
    int src_gap_pct;
    int snk_stall_pct;
    int stall_hold;

    // Button pattern of the random traffic.
    logic btn_now;
    int   btn_ticks_left;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Overall time limit.
    initial begin
        #20_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // Linear map of a light sample onto out_lo..255, saturated.
    function automatic logic [DUTY_W-1:0] light_map(input logic [LIGHT_W-1:0] x,
                                                    input logic [THR_W-1:0] thr,
                                                    input int out_lo);
        int den;
        int num;
        int r;
        den = FULL_SCALE - int'(thr);
        num = int'(x) - int'(thr);
        if (den == 0) begin
            return (num == 0) ? DUTY_W'(out_lo) : '0;
        end
        r = num * (255 - out_lo) / den + out_lo;
        if (r < 0) begin
            r = 0;
        end else if (r > 255) begin
            r = 255;
        end
        return DUTY_W'(r);
    endfunction

    // Advance the predicted controller by one tick and queue its result.
    task automatic predict_drive(input t_tick t);
        t_result             r;
        logic                reversing_now;
        logic [DUTY_W-1:0]   led_l;
        logic [DUTY_W-1:0]   led_r;
        logic [DUTY_W-1:0]   lf;
        logic [DUTY_W-1:0]   rf;
        logic [4*DUTY_W-1:0] motors;
        logic [4*DUTY_W-1:0] rev_motors;

        rev_motors    = {DUTY_W'(0), REVERSE_DUTY, DUTY_W'(0), REVERSE_DUTY};
        reversing_now = 1'b0;
        led_l         = man_leds[15:8];
        led_r         = man_leds[7:0];
        motors        = held_duty;

        // An app command is applied even during a reverse phase.
        if (t.app_cmd_valid) begin
            run_on = 1'b1;
            app_on = t.app_cmd_state;
        end

        if (rev_ticks_left != '0) begin
            rev_ticks_left--;
            reversing_now = 1'b1;
        end else begin
            // Button: short presses set run and toggle app mode, long ones stop.
            if (t.button_level != btn_was) begin
                if (t.button_level) begin
                    press_ticks = PRESS_W'(1);
                end else if (press_ticks < SHORT_PRESS) begin
                    app_on = ~app_on;
                    run_on = 1'b1;
                end else begin
                    app_on = 1'b0;
                    run_on = 1'b0;
                end
            end else if (t.button_level && press_ticks < PRESS_MAX) begin
                press_ticks++;
            end
            btn_was = t.button_level;

            // Obstacle: reverse duties held; with no reverse time app or light mode may replace them.
            if (run_on && mode_bits[MODE_OBST] && !t.obstacle_level) begin
                held_duty = rev_motors;
                motors    = rev_motors;
                if (rev_len != '0) begin
                    rev_ticks_left = rev_len - 1'b1;
                    reversing_now  = 1'b1;
                end
            end

            if (!reversing_now) begin
                if (run_on && app_on) begin
                    motors = {man_left_drv, man_right_drv};
                end else if (run_on && mode_bits[MODE_LIGHT]) begin
                    led_l = light_map(t.light_left, light_thr, int'(LED_MAP_LO));
                    led_r = light_map(t.light_right, light_thr, int'(LED_MAP_LO));
                    if (t.light_left > light_thr || t.light_right > light_thr) begin
                        if (mode_bits[MODE_PARALLEL]) begin
                            lf = light_map(t.light_left, light_thr, int'(MOTOR_MAP_LO));
                            rf = light_map(t.light_right, light_thr, int'(MOTOR_MAP_LO));
                        end else begin
                            lf = light_map(t.light_right, light_thr, int'(MOTOR_MAP_LO));
                            rf = light_map(t.light_left, light_thr, int'(MOTOR_MAP_LO));
                        end
                        motors = {lf, DUTY_W'(0), rf, DUTY_W'(0)};
                    end else begin
                        motors = '0;
                    end
                end else if (!run_on) begin
                    motors = '0;
                end
                held_duty = motors;
            end
        end

        if (reversing_now) begin
            motors = rev_motors;
            led_l  = REVERSE_LED;
            led_r  = REVERSE_LED;
        end

        r.motor_left_fwd   = motors[31:24];
        r.motor_left_back  = motors[23:16];
        r.motor_right_fwd  = motors[15:8];
        r.motor_right_back = motors[7:0];
        r.led_left         = led_l;
        r.led_right        = led_r;
        r.running          = run_on;
        r.app_mode         = app_on;
        r.reversing        = reversing_now;
        pending_drive.push_back(r);
    endtask

    function automatic t_tick make_tick(input logic btn, input logic obst,
                                        input logic [LIGHT_W-1:0] ll,
                                        input logic [LIGHT_W-1:0] lr,
                                        input logic cmd_valid, input logic cmd_state);
        t_tick t;
        t.button_level   = btn;
        t.obstacle_level = obst;
        t.light_left     = ll;
        t.light_right    = lr;
        t.app_cmd_valid  = cmd_valid;
        t.app_cmd_state  = cmd_state;
        return t;
    endfunction

    // Offer one tick, wait for its transfer and predict its result. Valid is
    // left high so that the next tick can follow without a gap.
    task automatic send_tick(input t_tick t);
        @(negedge i_clk);
        while ($urandom_range(99) < src_gap_pct) begin
            tick_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        tick_ch.button_level   = t.button_level;
        tick_ch.obstacle_level = t.obstacle_level;
        tick_ch.light_left     = t.light_left;
        tick_ch.light_right    = t.light_right;
        tick_ch.app_cmd_valid  = t.app_cmd_valid;
        tick_ch.app_cmd_state  = t.app_cmd_state;
        tick_ch.valid          = 1'b1;
        do @(posedge i_clk); while (!tick_ch.ready);
        predict_drive(t);
    endtask

    // Stop offering ticks and wait until every predicted result has arrived.
    task automatic settle_block();
        @(negedge i_clk);
        tick_ch.valid = 1'b0;
        while (pending_drive.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Register write; only called while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        @(negedge i_clk);
        cfg_we   = 1'b0;
        case (idx)
            CFG_MANUAL_LEFT:  man_left_drv  = val;
            CFG_MANUAL_RIGHT: man_right_drv = val;
            CFG_MANUAL_LEDS:  man_leds      = val;
            CFG_THRESHOLD:    light_thr     = val[THR_W-1:0];
            CFG_REVERSE_MS:   rev_len       = val[REV_W-1:0];
            CFG_MODE_FLAGS:   mode_bits     = val[MODE_W-1:0];
            default: ;
        endcase
    endtask

    // Hold the button for a number of ticks, then release it.
    task automatic press_for(input int n_ticks);
        repeat (n_ticks) send_tick(make_tick(1'b1, 1'b1, '0, '0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b1, '0, '0, 1'b0, 1'b0));
    endtask

    // Light sample for the random traffic, often close to the threshold.
    function automatic logic [LIGHT_W-1:0] random_light();
        int v;
        case ($urandom_range(3))
            0: v = int'(light_thr) + int'($urandom_range(8)) - 4;
            1: v = $urandom_range(1) ? FULL_SCALE : 0;
            default: v = $urandom_range(FULL_SCALE);
        endcase
        if (v < 0) begin
            v = 0;
        end else if (v > FULL_SCALE) begin
            v = FULL_SCALE;
        end
        return LIGHT_W'(v);
    endfunction

    // Random tick: button presses of random length, now and then a long one,
    // rare obstacles and app commands.
    function automatic t_tick random_tick();
        t_tick t;
        if (btn_ticks_left == 0) begin
            btn_now = ~btn_now;
            if (btn_now) begin
                btn_ticks_left = ($urandom_range(149) == 0) ? $urandom_range(495, 520)
                                                            : $urandom_range(1, 25);
            end else begin
                btn_ticks_left = $urandom_range(1, 40);
            end
        end
        btn_ticks_left--;
        t.button_level   = btn_now;
        t.obstacle_level = ($urandom_range(24) != 0);
        t.light_left     = random_light();
        t.light_right    = random_light();
        t.app_cmd_valid  = ($urandom_range(11) == 0);
        t.app_cmd_state  = $urandom_range(1);
        return t;
    endfunction

    // New register settings for a block of random traffic.
    task automatic randomise_settings();
        logic [CFG_DATA_W-1:0] thr;
        case ($urandom_range(5))
            0: thr = '0;
            1: thr = CFG_DATA_W'(FULL_SCALE - 1);
            2: thr = CFG_DATA_W'(FULL_SCALE);
            default: thr = CFG_DATA_W'($urandom_range(FULL_SCALE));
        endcase
        write_reg(CFG_MANUAL_LEFT, CFG_DATA_W'($urandom_range(16'hFFFF)));
        write_reg(CFG_MANUAL_RIGHT, CFG_DATA_W'($urandom_range(16'hFFFF)));
        write_reg(CFG_MANUAL_LEDS, CFG_DATA_W'($urandom_range(16'hFFFF)));
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_REVERSE_MS, ($urandom_range(9) == 0) ? '0
                                  : CFG_DATA_W'($urandom_range(1, 6)));
        write_reg(CFG_MODE_FLAGS, CFG_DATA_W'($urandom_range(7)));
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial begin
        drive_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_hold > 0) begin
                drive_ch.ready = 1'b0;
                stall_hold--;
            end else begin
                drive_ch.ready = ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            n_errors++;
            if (n_reports < MAX_REPORTS) begin
                n_reports++;
                $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            end
        end
    endfunction

    // Each result transfer is compared with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && drive_ch.valid && drive_ch.ready) begin
            if (pending_drive.size() == 0) begin
                n_errors++;
                if (n_reports < MAX_REPORTS) begin
                    n_reports++;
                    $display("%0t ns: result transfer with no tick pending", $time);
                end
            end else begin
                want = pending_drive.pop_front();
                check_field("motor_left_fwd", want.motor_left_fwd, drive_ch.motor_left_fwd);
                check_field("motor_left_back", want.motor_left_back,
                            drive_ch.motor_left_back);
                check_field("motor_right_fwd", want.motor_right_fwd,
                            drive_ch.motor_right_fwd);
                check_field("motor_right_back", want.motor_right_back,
                            drive_ch.motor_right_back);
                check_field("led_left", want.led_left, drive_ch.led_left);
                check_field("led_right", want.led_right, drive_ch.led_right);
                check_field("running", want.running, drive_ch.running);
                check_field("app_mode", want.app_mode, drive_ch.app_mode);
                check_field("reversing", want.reversing, drive_ch.reversing);
            end
        end
    end

    // While stopped the motors are off and the LEDs show the manual value.
    task automatic test_stopped();
        send_tick(make_tick(1'b0, 1'b1, '0, '0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b0, '1, '1, 1'b0, 1'b0));
        settle_block();
        write_reg(CFG_MANUAL_LEDS, 16'hFFFF);
        write_reg(CFG_MODE_FLAGS, MODE_LIGHT_ON | MODE_OBST_ON | MODE_PARALLEL_ON);
        send_tick(make_tick(1'b0, 1'b0, '1, '0, 1'b0, 1'b0));
        settle_block();
    endtask

    // App commands start the block; app mode drives the manual values and
    // with neither mode the last duties are held.
    task automatic test_app_control();
        write_reg(CFG_MODE_FLAGS, MODE_NONE);
        write_reg(CFG_MANUAL_LEFT, 16'hFF00);
        write_reg(CFG_MANUAL_RIGHT, 16'h00FF);
        write_reg(CFG_MANUAL_LEDS, 16'hA55A);
        send_tick(make_tick(1'b0, 1'b1, 12'h800, 12'h7FF, 1'b1, 1'b1));
        send_tick(make_tick(1'b0, 1'b1, 12'h800, 12'h7FF, 1'b1, 1'b0));
        send_tick(make_tick(1'b0, 1'b1, '0, '0, 1'b0, 1'b0));
        settle_block();
        write_reg(CFG_MANUAL_LEFT, 16'hFFFF);
        write_reg(CFG_MANUAL_RIGHT, 16'h0000);
        send_tick(make_tick(1'b0, 1'b1, '0, '0, 1'b1, 1'b1));
        send_tick(make_tick(1'b0, 1'b1, '1, '1, 1'b0, 1'b0));
        settle_block();
    endtask

    // Short presses toggle app mode; an app command in the release tick is
    // applied before the toggle.
    task automatic test_short_press();
        press_for(1);
        press_for(3);
        send_tick(make_tick(1'b1, 1'b1, '0, '0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b1, '0, '0, 1'b1, 1'b1));
        settle_block();
    endtask

    // Light maps around the threshold, cross and parallel wiring, and the
    // empty map range at full-scale threshold.
    task automatic test_light_maps();
        write_reg(CFG_MODE_FLAGS, MODE_LIGHT_ON);
        write_reg(CFG_THRESHOLD, '0);
        send_tick(make_tick(1'b0, 1'b1, '0, '0, 1'b1, 1'b0));
        send_tick(make_tick(1'b0, 1'b1, '1, '0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b1, 12'd1, 12'd2048, 1'b0, 1'b0));
        settle_block();
        write_reg(CFG_THRESHOLD, 16'd2048);
        send_tick(make_tick(1'b0, 1'b1, 12'd2048, 12'd2047, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b1, 12'd2049, 12'd100, 1'b0, 1'b0));
        settle_block();
        write_reg(CFG_MODE_FLAGS, MODE_LIGHT_ON | MODE_PARALLEL_ON);
        send_tick(make_tick(1'b0, 1'b1, '1, 12'd2049, 1'b0, 1'b0));
        settle_block();
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(FULL_SCALE));
        send_tick(make_tick(1'b0, 1'b1, '1, LIGHT_W'(FULL_SCALE - 1), 1'b0, 1'b0));
        settle_block();
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(FULL_SCALE - 1));
        send_tick(make_tick(1'b0, 1'b1, '1, LIGHT_W'(FULL_SCALE - 1), 1'b0, 1'b0));
        settle_block();
    endtask

    // Obstacle reverse phase: button ignored and app commands applied during
    // it, zero reverse time, and a single reverse tick.
    task automatic test_obstacle();
        write_reg(CFG_MODE_FLAGS, MODE_OBST_ON);
        write_reg(CFG_REVERSE_MS, 16'd3);
        send_tick(make_tick(1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
        send_tick(make_tick(1'b1, 1'b1, '0, '0, 1'b1, 1'b1));
        send_tick(make_tick(1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b1, '0, '0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b1, '0, '0, 1'b1, 1'b0));
        settle_block();
        write_reg(CFG_REVERSE_MS, '0);
        send_tick(make_tick(1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b1, '0, '0, 1'b0, 1'b0));
        settle_block();
        write_reg(CFG_REVERSE_MS, 16'd1);
        send_tick(make_tick(1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
        settle_block();
        write_reg(CFG_MODE_FLAGS, MODE_NONE);
        write_reg(CFG_REVERSE_MS, 16'hFFFF);
        send_tick(make_tick(1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
        settle_block();
        write_reg(CFG_REVERSE_MS, 16'd2);
    endtask

    // A press just below the long-press limit, and one just past the
    // saturation of the press counter.
    task automatic test_long_press();
        write_reg(CFG_MODE_FLAGS, MODE_NONE);
        press_for(int'(SHORT_PRESS) - 1);
        press_for(int'(PRESS_MAX) + 2);
        settle_block();
    endtask

    // The receiver holds off for a long stretch while ticks keep coming, so
    // the block fills up and stalls its input.
    task automatic test_backpressure();
        src_gap_pct   = 0;
        snk_stall_pct = 0;
        write_reg(CFG_MODE_FLAGS, MODE_LIGHT_ON);
        write_reg(CFG_THRESHOLD, 16'd1000);
        stall_hold = 400;
        send_tick(make_tick(1'b0, 1'b1, 12'd3000, 12'd500, 1'b1, 1'b0));
        repeat (15) send_tick(make_tick(1'b0, 1'b1, random_light(), random_light(),
                                        1'b0, 1'b0));
        settle_block();
    endtask

    // Random traffic in blocks, each with fresh register settings.
    task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                       input int n_ticks);
        int sent;
        src_gap_pct   = gap_pct;
        snk_stall_pct = stall_pct;
        sent          = 0;
        while (sent < n_ticks) begin
            settle_block();
            randomise_settings();
            repeat (RANDOM_BLOCK) send_tick(random_tick());
            sent += RANDOM_BLOCK;
        end
        settle_block();
    endtask

    initial begin
        i_rst_n                = 1'b0;
        cfg_we                 = 1'b0;
        cfg_idx                = '0;
        cfg_data               = '0;
        tick_ch.valid          = 1'b0;
        tick_ch.button_level   = 1'b0;
        tick_ch.obstacle_level = 1'b1;
        tick_ch.light_left     = '0;
        tick_ch.light_right    = '0;
        tick_ch.app_cmd_valid  = 1'b0;
        tick_ch.app_cmd_state  = 1'b0;

        man_left_drv   = '0;
        man_right_drv  = '0;
        man_leds       = '0;
        light_thr      = '0;
        rev_len        = '0;
        mode_bits      = '0;
        run_on         = 1'b0;
        app_on         = 1'b0;
        btn_was        = 1'b0;
        press_ticks    = '0;
        rev_ticks_left = '0;
        held_duty      = '0;
        btn_now        = 1'b0;
        btn_ticks_left = 0;
        n_errors       = 0;
        n_reports      = 0;
        src_gap_pct    = 31;
        snk_stall_pct  = 61;
        stall_hold     = 0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_stopped();
        test_app_control();
        test_short_press();
        test_light_maps();
        test_obstacle();
        test_long_press();
        test_backpressure();
        test_random_traffic(31, 61, RANDOM_BLOCK);
        test_random_traffic(61, 31, RANDOM_BLOCK);
        test_random_traffic(0, 0, RANDOM_BLOCK);

        repeat (TICK_LATENCY) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
